[sv/sui_pkg.sv]
// ----------------------------------------------------------------------------
// sui_pkg: shared types and constants for the set union / intersection unit
// Sizes, function codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sui_pkg;

   localparam int DEPTH   = 8;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int FUNC_W  = 2;
   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [IDX_W-1:0]          idx_type;
   typedef logic [CNT_W-1:0]          cnt_type;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_COMPUTE = 2'd2
   } func_type;

   typedef enum logic {
      MODE_UNION = 1'b0,
      MODE_INTER = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT_A,
      ST_SCAN_B,
      ST_INTER,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic start;
      logic inc_ia;
      logic clr_ia;
      logic inc_ib;
      logic clr_ib;
      logic set_seen;
      logic clr_seen;
      logic capture;
      logic cap_from_b;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic     na_zero;
      logic     nb_zero;
      logic     ia_end;
      logic     ib_end;
      logic     match;
      logic     seen;
      logic     pend_valid;
      logic     slot_free;
      mode_type mode;
   } ctl_status_type;

endpackage

[sv/sui_if.sv]
// ----------------------------------------------------------------------------
// sui_if: request and response channels
// Valid / ready channels carrying one request and one result item.
// ----------------------------------------------------------------------------
interface sui_req_if import sui_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface sui_rsp_if import sui_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value_out;
   logic                      present;
   logic                      overflow;
   logic                      last;

   modport source (output valid, output value_out, output present, output overflow,
                   output last, input ready);
   modport sink   (input valid, input value_out, input present, input overflow,
                   input last, output ready);
endinterface

[sv/set_union_intersection.sv]
// ----------------------------------------------------------------------------
// set_union_intersection: set union / intersection unit
// Loads two small sets of signed 32-bit values and emits their union or
// intersection as selected by the mode register.
// ----------------------------------------------------------------------------
// Usage: send requests with func 0 to append value to set A and func 1 to
// append to set B; an append gives no result. Up to
// DEPTH (8) elements fit in each set; further appends are dropped and the
// overflow flag is raised on every result of the next compute. A request with
// func 2 computes the answer chosen by csr_wr_data (0 union, 1 intersection,
// written with csr_wr_en while the unit is idle) and returns one result per
// element, the final one marked last; an empty answer returns a single result
// with present low. Both sets are emptied afterwards; func 3 does nothing.
// Timing: a compute is walked by one comparator, one compare per cycle unless
// a stalled response channel holds it. No request is taken until the compute
// has handed its last result to the output register; that register decouples
// the response side, so new requests are accepted while the final result
// still waits.
// ----------------------------------------------------------------------------
module set_union_intersection import sui_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   sui_req_if.sink       req,
   sui_rsp_if.source     rsp,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data
);

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           req_ready;

   // sequence the phases: load, emit A, scan B against A or cross compare
   sui_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_func  (req.func),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the sets, counters and result register
   sui_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req.value),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp.ready),
      .rsp_valid     (rsp.valid),
      .rsp_value_out (rsp.value_out),
      .rsp_present   (rsp.present),
      .rsp_overflow  (rsp.overflow),
      .rsp_last      (rsp.last)
   );

   assign req.ready = req_ready;

endmodule

[sv/sui_ctrl.sv]
// ----------------------------------------------------------------------------
// sui_ctrl: sequencing controller
// Walks the load, emit and compare phases and issues datapath commands.
// ----------------------------------------------------------------------------
module sui_ctrl import sui_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   input  ctl_status_type    status,
   output ctl_cmd_type       cmd
);

   state_type state_ff, state_in;

   logic hit;
   logic inner_done;
   logic b_new;
   logic cap_want;
   logic stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // loop conditions shared by both blocks below
   always_comb begin
      hit        = status.match && !status.na_zero;
      inner_done = status.na_zero || status.ia_end;
      b_new      = inner_done && !(status.seen || hit);
      case (state_ff)
         ST_EMIT_A: cap_want = !status.na_zero;
         ST_SCAN_B: cap_want = !status.nb_zero && b_new;
         ST_INTER:  cap_want = !status.na_zero && !status.nb_zero && status.match;
         default:   cap_want = 1'b0;
      endcase
      // hold when a new element must push the pending one into a full slot
      stall = cap_want && status.pend_valid && !status.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_func == FUNC_COMPUTE)) begin
               state_in = (status.mode == MODE_INTER) ? ST_INTER : ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            if (status.na_zero || (!stall && status.ia_end)) begin
               state_in = ST_SCAN_B;
            end
         end
         ST_SCAN_B: begin
            if (status.nb_zero || (!stall && inner_done && status.ib_end)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_INTER: begin
            if (status.na_zero || status.nb_zero ||
                (!stall && status.ia_end && status.ib_end)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (status.slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  FUNC_LOAD_A:  cmd.load_a = 1'b1;
                  FUNC_LOAD_B:  cmd.load_b = 1'b1;
                  FUNC_COMPUTE: cmd.start  = 1'b1;
                  default:      cmd.start  = 1'b0;
               endcase
            end
         end
         ST_EMIT_A: begin
            if (!status.na_zero && !stall) begin
               cmd.capture = 1'b1;
               cmd.inc_ia  = 1'b1;
               cmd.clr_ia  = status.ia_end;
            end
         end
         ST_SCAN_B: begin
            if (!status.nb_zero && !stall) begin
               if (inner_done) begin
                  cmd.capture    = b_new;
                  cmd.cap_from_b = 1'b1;
                  cmd.clr_ia     = 1'b1;
                  cmd.clr_seen   = 1'b1;
                  cmd.inc_ib     = 1'b1;
               end else begin
                  cmd.inc_ia   = 1'b1;
                  cmd.set_seen = hit;
               end
            end
         end
         ST_INTER: begin
            if (!status.na_zero && !status.nb_zero && !stall) begin
               cmd.capture = status.match;
               if (status.ib_end) begin
                  cmd.clr_ib = 1'b1;
                  cmd.inc_ia = 1'b1;
               end else begin
                  cmd.inc_ib = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            cmd.flush = status.slot_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[sv/sui_dpath.sv]
// ----------------------------------------------------------------------------
// sui_dpath: set storage, compare indices and result register
// Holds both sets, the fill counts, the mode register, one pending element
// and the output register.
// ----------------------------------------------------------------------------
module sui_dpath import sui_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  value_type      req_value,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   input  logic           rsp_ready,
   output logic           rsp_valid,
   output value_type      rsp_value_out,
   output logic           rsp_present,
   output logic           rsp_overflow,
   output logic           rsp_last
);

   value_type set_a_ff [DEPTH];
   value_type set_b_ff [DEPTH];

   cnt_type   count_a_ff, count_a_in;
   cnt_type   count_b_ff, count_b_in;
   logic      dropped_ff, dropped_in;
   mode_type  mode_ff, mode_in;
   idx_type   ia_ff, ia_in;
   idx_type   ib_ff, ib_in;
   logic      seen_ff, seen_in;
   logic      pend_valid_ff, pend_valid_in;
   value_type pend_value_ff, pend_value_in;
   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff, rsp_value_in;
   logic      rsp_present_ff, rsp_present_in;
   logic      rsp_overflow_ff, rsp_overflow_in;
   logic      rsp_last_ff, rsp_last_in;

   value_type elem_a;
   value_type elem_b;
   logic      room_a;
   logic      room_b;
   logic      slot_free;

   assign elem_a    = set_a_ff[ia_ff];
   assign elem_b    = set_b_ff[ib_ff];
   assign room_a    = count_a_ff < CNT_W'(DEPTH);
   assign room_b    = count_b_ff < CNT_W'(DEPTH);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      status.na_zero    = count_a_ff == '0;
      status.nb_zero    = count_b_ff == '0;
      status.ia_end     = (CNT_W'(ia_ff) + CNT_W'(1)) == count_a_ff;
      status.ib_end     = (CNT_W'(ib_ff) + CNT_W'(1)) == count_b_ff;
      status.match      = elem_a == elem_b;
      status.seen       = seen_ff;
      status.pend_valid = pend_valid_ff;
      status.slot_free  = slot_free;
      status.mode       = mode_ff;
   end

   // append into storage; no reset, only entries below the count are read
   always_ff @(posedge clock) begin
      if (cmd.load_a && room_a) begin
         set_a_ff[count_a_ff[IDX_W-1:0]] <= req_value;
      end
      if (cmd.load_b && room_b) begin
         set_b_ff[count_b_ff[IDX_W-1:0]] <= req_value;
      end
   end

   always_comb begin
      count_a_in = count_a_ff;
      count_b_in = count_b_ff;
      dropped_in = dropped_ff;
      mode_in    = csr_wr_en ? mode_type'(csr_wr_data) : mode_ff;
      if (cmd.load_a) begin
         if (room_a) begin
            count_a_in = count_a_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.load_b) begin
         if (room_b) begin
            count_b_in = count_b_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.flush) begin
         count_a_in = '0;
         count_b_in = '0;
         dropped_in = 1'b0;
      end
   end

   always_comb begin
      ia_in   = ia_ff;
      ib_in   = ib_ff;
      seen_in = seen_ff;
      if (cmd.inc_ia) ia_in = ia_ff + IDX_W'(1);
      if (cmd.clr_ia || cmd.start) ia_in = '0;
      if (cmd.inc_ib) ib_in = ib_ff + IDX_W'(1);
      if (cmd.clr_ib || cmd.start) ib_in = '0;
      if (cmd.set_seen) seen_in = 1'b1;
      if (cmd.clr_seen || cmd.start) seen_in = 1'b0;
   end

   // one element is held back so the final one can carry last
   always_comb begin
      pend_valid_in   = pend_valid_ff;
      pend_value_in   = pend_value_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_value_in    = rsp_value_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_overflow_in = rsp_overflow_ff;
      rsp_last_in     = rsp_last_ff;
      if (cmd.capture) begin
         pend_valid_in = 1'b1;
         pend_value_in = cmd.cap_from_b ? elem_b : elem_a;
         if (pend_valid_ff) begin
            rsp_valid_in    = 1'b1;
            rsp_value_in    = pend_value_ff;
            rsp_present_in  = 1'b1;
            rsp_overflow_in = dropped_ff;
            rsp_last_in     = 1'b0;
         end
      end
      if (cmd.flush) begin
         pend_valid_in   = 1'b0;
         rsp_valid_in    = 1'b1;
         rsp_value_in    = pend_valid_ff ? pend_value_ff : '0;
         rsp_present_in  = pend_valid_ff;
         rsp_overflow_in = dropped_ff;
         rsp_last_in     = 1'b1;
      end
      if (cmd.start) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff    <= '0;
         count_b_ff    <= '0;
         dropped_ff    <= 1'b0;
         mode_ff       <= MODE_UNION;
         ia_ff         <= '0;
         ib_ff         <= '0;
         seen_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_a_ff    <= count_a_in;
         count_b_ff    <= count_b_in;
         dropped_ff    <= dropped_in;
         mode_ff       <= mode_in;
         ia_ff         <= ia_in;
         ib_ff         <= ib_in;
         seen_ff       <= seen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff   <= pend_value_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_overflow_ff <= rsp_overflow_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_present   = rsp_present_ff;
   assign rsp_overflow  = rsp_overflow_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[sv/sui_checker.sv]
// ----------------------------------------------------------------------------
// sui_checker: port-level checks for the set union / intersection unit
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module sui_checker import sui_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [FUNC_W-1:0] req_func,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input value_type         rsp_value_out,
   input logic              rsp_present,
   input logic              rsp_last
);

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_out) &&
      $stable(rsp_present) && $stable(rsp_last))
      else $error("response changed while stalled");

   // an empty answer is a single zero result that ends the compute
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_last && (rsp_value_out == '0))
      else $error("empty answer not marked last or not zero");

   // a compute request makes the unit busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_COMPUTE) |=> !req_ready)
      else $error("request taken during compute");

   // reset drops any pending result
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind set_union_intersection sui_checker u_sui_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .req_func      (req.func),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_value_out (rsp.value_out),
   .rsp_present   (rsp.present),
   .rsp_last      (rsp.last)
);

[tb/tb_set_union_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_set_union_intersection: self-checking bench for the set union unit
// Loads sets A and B through the request channel, computes union or
// intersection under both mode settings and compares every result against
// an in-bench model of the two sets. A directed table covers empty answers,
// value extremes, duplicates, full sets and the unused function code; random
// load / compute sequences follow, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_set_union_intersection;
   import sui_pkg::*;

   // Function code that the unit must ignore
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 75;    // random requests that change state
   localparam int CALM_FROM    = 60;    // no idling once this many are sent
   localparam int IDLE_SETTLE  = 4;     // cycles for a trailing append to land
   localparam int DRAIN_CYCLES = 100;   // watch for stray results at the end
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      value_type value_out;
      logic      present;
      logic      overflow;
      logic      last;
   } answer_item;

   // One row of the directed table: either a mode write or a request,
   // repeated rep times; typed rows carry their single result as written.
   typedef struct packed {
      logic              wr_mode;
      mode_type          mode_val;
      logic [FUNC_W-1:0] func;
      value_type         value;
      logic [3:0]        rep;
      logic              typed;
      answer_item        ans;
   } stim_row;

   localparam answer_item NO_ANS    = '0;
   localparam answer_item EMPTY_ANS = '{32'h0, 1'b0, 1'b0, 1'b1};
   localparam answer_item EMPTY_OVF = '{32'h0, 1'b0, 1'b1, 1'b1};

   localparam int NUM_ROWS = 22;

   stim_row directed_rows [NUM_ROWS] = '{
      // union phase
      '{1'b1, MODE_UNION, FUNC_UNUSED,  32'h0,         4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_COMPUTE, 32'h0,         4'd1, 1'b1, EMPTY_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_A,  32'h8000_0000, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_A,  32'h7FFF_FFFF, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_A,  32'h7FFF_FFFF, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_B,  32'h7FFF_FFFF, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_B,  32'hFFFF_FFFF, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_UNUSED,  32'h1234_5678, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_LOAD_B,  32'hFFFF_FFFF, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_UNION, FUNC_COMPUTE, 32'hFFFF_FFFF, 4'd1, 1'b0, NO_ANS},
      // intersection phase
      '{1'b1, MODE_INTER, FUNC_UNUSED,  32'h0,         4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_COMPUTE, 32'h0,         4'd1, 1'b1, EMPTY_ANS},
      '{1'b0, MODE_INTER, FUNC_LOAD_A,  32'h8000_0000, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_LOAD_B,  32'h8000_0000, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_LOAD_B,  32'h8000_0000, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_LOAD_B,  32'h0000_0000, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_COMPUTE, 32'h0,         4'd1, 1'b0, NO_ANS},
      // nine appends to A: the last one is dropped, B gets nothing in common
      '{1'b0, MODE_INTER, FUNC_LOAD_A,  32'h0000_0003, 4'd9, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_LOAD_B,  32'h0000_0004, 4'd1, 1'b0, NO_ANS},
      '{1'b0, MODE_INTER, FUNC_COMPUTE, 32'h0,         4'd1, 1'b1, EMPTY_OVF},
      // compute right after a compute sees two empty sets
      '{1'b0, MODE_INTER, FUNC_COMPUTE, 32'h0,         4'd1, 1'b1, EMPTY_ANS},
      '{1'b1, MODE_UNION, FUNC_UNUSED,  32'h0,         4'd1, 1'b0, NO_ANS}
   };

   value_type corner_vals [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   sui_req_if req_ch ();
   sui_rsp_if rsp_ch ();

   set_union_intersection dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Model state: the two sets, their fill counts, the dropped flag and mode
   value_type  elem_a [DEPTH];
   value_type  elem_b [DEPTH];
   int         count_a = 0;
   int         count_b = 0;
   logic       lost    = 1'b0;
   mode_type   mode_q  = MODE_UNION;

   answer_item answer_q [$];   // results still owed by the unit, oldest first
   int         errors      = 0;
   int         cycle_count = 0;
   bit         calm        = 1'b0;   // set to stop idling on both sides
   int         ready_hold  = 0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Append one expected result; present low means an empty answer
   function automatic void push_answer(value_type v, logic pres);
      answer_q.push_back('{v, pres, lost, 1'b0});
   endfunction

   // Apply one accepted request to the model sets and queue what it yields
   function automatic void take_request(logic [FUNC_W-1:0] f, value_type v);
      int  base;
      bit  seen;
      base = answer_q.size();
      if (f == FUNC_LOAD_A) begin
         if (count_a < DEPTH) begin
            elem_a[count_a] = v;
            count_a++;
         end else begin
            lost = 1'b1;
         end
      end else if (f == FUNC_LOAD_B) begin
         if (count_b < DEPTH) begin
            elem_b[count_b] = v;
            count_b++;
         end else begin
            lost = 1'b1;
         end
      end else if (f == FUNC_COMPUTE) begin
         if (mode_q == MODE_UNION) begin
            // all of A, then the B elements that match nothing in A
            for (int i = 0; i < count_a; i++)
               push_answer(elem_a[i], 1'b1);
            for (int i = 0; i < count_b; i++) begin
               seen = 1'b0;
               for (int j = 0; j < count_a; j++)
                  if (elem_b[i] == elem_a[j])
                     seen = 1'b1;
               if (!seen)
                  push_answer(elem_b[i], 1'b1);
            end
         end else begin
            // one copy of each A element per equal B element
            for (int i = 0; i < count_a; i++)
               for (int j = 0; j < count_b; j++)
                  if (elem_a[i] == elem_b[j])
                     push_answer(elem_a[i], 1'b1);
         end
         if (answer_q.size() == base)
            push_answer('0, 1'b0);
         answer_q[answer_q.size() - 1].last = 1'b1;
         count_a = 0;
         count_b = 0;
         lost    = 1'b0;
      end
   endfunction

   // Drive one request from a falling edge and hold it until accepted.
   // Valid stays high on return so back-to-back requests need no toggle.
   task automatic send_request(input logic [FUNC_W-1:0] f, input value_type v,
                               input logic typed, input answer_item typed_ans);
      int base;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= f;
      req_ch.value <= v;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      base = answer_q.size();
      take_request(f, v);
      // a typed row replaces what the model produced for it
      if (typed) begin
         while (answer_q.size() > base)
            void'(answer_q.pop_back());
         answer_q.push_back(typed_ans);
      end
      @(negedge clock);
   endtask

   // Write the mode register once the unit has gone quiet
   task automatic write_mode(input mode_type m);
      req_ch.valid <= 1'b0;
      while (answer_q.size() != 0)
         @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      mode_q = m;
   endtask

   // Response side: drop ready for random bursts
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= ready_hold - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         ready_hold   <= $urandom_range(0, 5);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Report one differing field of a result
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      answer_item want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (answer_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual value_out %h present %b",
                     $time, rsp_ch.value_out, rsp_ch.present);
         end else begin
            want = answer_q.pop_front();
            check_field("value_out", want.value_out, rsp_ch.value_out);
            check_field("present", 32'(want.present), 32'(rsp_ch.present));
            check_field("overflow", 32'(want.overflow), 32'(rsp_ch.overflow));
            check_field("last", 32'(want.last), 32'(rsp_ch.last));
         end
      end
   end

   // Hard stop if the unit hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_set_union_intersection failed");
         $finish;
      end
   end

   initial begin
      stim_row           row;
      value_type         pool [4];
      logic [FUNC_W-1:0] f;
      int                na;
      int                nb;
      int                loaded;

      // known values on every input from time zero
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.func  = FUNC_LOAD_A;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      loaded       = 0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table: mode writes wait for quiet, requests repeat rep times
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         if (row.wr_mode) begin
            write_mode(row.mode_val);
         end else begin
            for (int k = 0; k < row.rep; k++)
               send_request(row.func, row.value, row.typed, row.ans);
         end
      end

      // Random phases: pick a mode, load both sets from a small value pool so
      // that matches are common, sprinkle in ignored requests, then compute.
      while (loaded < RANDOM_ITEMS) begin
         calm = (loaded >= CALM_FROM);
         write_mode(mode_type'($urandom_range(0, 1)));
         for (int k = 0; k < 4; k++)
            pool[k] = ($urandom_range(0, 5) == 0) ? corner_vals[$urandom_range(0, 3)]
                                                  : value_type'($urandom);
         // mostly legal fill levels, now and then past full
         na = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 3)
                                          : $urandom_range(0, DEPTH);
         nb = ($urandom_range(0, 5) == 0) ? $urandom_range(DEPTH + 1, DEPTH + 3)
                                          : $urandom_range(0, DEPTH);
         while (na + nb > 0) begin
            if (na > 0 && (nb == 0 || $urandom_range(0, 1) == 0)) begin
               f = FUNC_LOAD_A;
               na--;
            end else begin
               f = FUNC_LOAD_B;
               nb--;
            end
            if ($urandom_range(0, 11) == 0)
               send_request(FUNC_UNUSED, value_type'($urandom), 1'b0, NO_ANS);
            send_request(f, ($urandom_range(0, 3) == 0) ? value_type'($urandom)
                                                        : pool[$urandom_range(0, 3)],
                         1'b0, NO_ANS);
            loaded++;
         end
         send_request(FUNC_COMPUTE, value_type'($urandom), 1'b0, NO_ANS);
         loaded++;
      end

      // Drain: wait for every owed result, then watch for strays
      calm = 1'b1;
      req_ch.valid <= 1'b0;
      while (answer_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && answer_q.size() == 0)
         $display("tb_set_union_intersection passed");
      else
         $display("tb_set_union_intersection failed");
      $finish;
   end

endmodule
